### src/rfas_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rfas_pkg
// Shared types and constants for the reverse flow ack suppress table.
// ----------------------------------------------------------------------------
package rfas_pkg;

    localparam int TABLE_SLOTS = 128;
    localparam int IDX_W       = (TABLE_SLOTS > 2) ? $clog2(TABLE_SLOTS) : 1;

    localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(TABLE_SLOTS - 1);

    localparam logic OP_RECORD = 1'b0;
    localparam logic OP_CHECK  = 1'b1;

    typedef struct packed {
        logic [31:0] src_addr;
        logic [15:0] sport;
        logic [31:0] dst_addr;
        logic [15:0] dport;
        logic [31:0] ack;
    } t_entry;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_RESULT
    } t_state;

endpackage
`default_nettype wire

### src/reverse_flow_ack_suppress_table.sv
`default_nettype none
// ----------------------------------------------------------------------------
// reverse_flow_ack_suppress_table
// Table of recorded request flows; a check scans the entry memory one slot
// per cycle and invalidates the first slot that matches the reversed flow.
// ----------------------------------------------------------------------------
// Record: result registered in the next cycle; one item per cycle while
//        the output is not stalled. Check: one memory read per slot, the
//        scan ending on a hit or at the last slot; the result is registered
//        once the output is free, and the next item is taken once it is out.
// Reset clears the valid bits and the write pointer at once; entry memory
// contents are left as they are.
// ----------------------------------------------------------------------------
module reverse_flow_ack_suppress_table (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic        i_operation,
    input  wire logic [31:0] i_source_address,
    input  wire logic [15:0] i_source_port,
    input  wire logic [31:0] i_dest_address,
    input  wire logic [15:0] i_dest_port,
    input  wire logic [31:0] i_tcp_number,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic             o_matched
);

    rfas_pkg::t_entry mem [rfas_pkg::TABLE_SLOTS];

    rfas_pkg::t_state                  r_state, n_state;
    logic [rfas_pkg::TABLE_SLOTS-1:0]  r_slot_valid, n_slot_valid;
    logic [rfas_pkg::IDX_W-1:0]        r_wr_ptr, n_wr_ptr;
    logic [rfas_pkg::IDX_W-1:0]        r_rd_addr, n_rd_addr;
    logic                              r_issue, n_issue;
    logic                              r_cmp_en, n_cmp_en;
    logic                              r_cmp_vld, n_cmp_vld;
    logic [rfas_pkg::IDX_W-1:0]        r_cmp_addr, n_cmp_addr;
    rfas_pkg::t_entry                  r_key, n_key;
    rfas_pkg::t_entry                  r_rd_data;
    logic                              r_hit, n_hit;
    logic                              r_out_valid, n_out_valid;
    logic                              r_out_matched, n_out_matched;

    logic   out_free;
    logic   in_xfer;
    logic   wr_en;
    logic   cmp_hit;
    logic   cmp_last;
    rfas_pkg::t_entry wr_entry;

    assign out_free = !r_out_valid || !i_out_stall;
    assign o_in_stall = (r_state != rfas_pkg::ST_IDLE) || !out_free;
    assign in_xfer = i_in_valid && !o_in_stall;
    assign wr_en = in_xfer && (i_operation == rfas_pkg::OP_RECORD);

    assign wr_entry = '{src_addr: i_source_address, sport: i_source_port,
                        dst_addr: i_dest_address, dport: i_dest_port,
                        ack: i_tcp_number};

    assign cmp_hit  = r_cmp_en && r_cmp_vld && (r_rd_data == r_key);
    assign cmp_last = r_cmp_en && (r_cmp_addr == rfas_pkg::LAST_SLOT);

    assign o_out_valid = r_out_valid;
    assign o_matched   = r_out_matched;

    // entry memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[r_wr_ptr] <= wr_entry;
        end
        r_rd_data <= mem[r_rd_addr];
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            rfas_pkg::ST_IDLE: begin
                if (in_xfer && (i_operation == rfas_pkg::OP_CHECK)) begin
                    n_state = rfas_pkg::ST_SCAN;
                end
            end
            rfas_pkg::ST_SCAN: begin
                if (cmp_hit || cmp_last) begin
                    n_state = rfas_pkg::ST_RESULT;
                end
            end
            rfas_pkg::ST_RESULT: begin
                if (out_free) begin
                    n_state = rfas_pkg::ST_IDLE;
                end
            end
            default: n_state = rfas_pkg::ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_slot_valid  = r_slot_valid;
        n_wr_ptr      = r_wr_ptr;
        n_rd_addr     = r_rd_addr;
        n_issue       = 1'b0;
        n_cmp_en      = 1'b0;
        n_cmp_vld     = 1'b0;
        n_cmp_addr    = r_rd_addr;
        n_key         = r_key;
        n_hit         = r_hit;
        n_out_valid   = r_out_valid && i_out_stall;
        n_out_matched = r_out_matched;
        case (r_state)
            rfas_pkg::ST_IDLE: begin
                if (wr_en) begin
                    n_slot_valid[r_wr_ptr] = 1'b1;
                    n_wr_ptr = (r_wr_ptr == rfas_pkg::LAST_SLOT) ? '0 : r_wr_ptr + 1'b1;
                    n_out_valid   = 1'b1;
                    n_out_matched = 1'b0;
                end else if (in_xfer) begin
                    n_key = '{src_addr: i_dest_address, sport: i_dest_port,
                              dst_addr: i_source_address, dport: i_source_port,
                              ack: i_tcp_number};
                    n_rd_addr = '0;
                    n_issue   = 1'b1;
                end
            end
            rfas_pkg::ST_SCAN: begin
                n_cmp_en   = r_issue;
                n_cmp_vld  = r_slot_valid[r_rd_addr];
                n_cmp_addr = r_rd_addr;
                if (r_issue && (r_rd_addr != rfas_pkg::LAST_SLOT)) begin
                    n_rd_addr = r_rd_addr + 1'b1;
                    n_issue   = 1'b1;
                end
                if (cmp_hit) begin
                    n_slot_valid[r_cmp_addr] = 1'b0;
                    n_hit = 1'b1;
                end else begin
                    n_hit = 1'b0;
                end
            end
            rfas_pkg::ST_RESULT: begin
                if (out_free) begin
                    n_out_valid   = 1'b1;
                    n_out_matched = r_hit;
                end
            end
            default: begin
                n_out_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= rfas_pkg::ST_IDLE;
            r_slot_valid <= '0;
            r_wr_ptr     <= '0;
            r_issue      <= 1'b0;
            r_cmp_en     <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_slot_valid <= n_slot_valid;
            r_wr_ptr     <= n_wr_ptr;
            r_issue      <= n_issue;
            r_cmp_en     <= n_cmp_en;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_addr     <= n_rd_addr;
        r_cmp_vld     <= n_cmp_vld;
        r_cmp_addr    <= n_cmp_addr;
        r_key         <= n_key;
        r_hit         <= n_hit;
        r_out_matched <= n_out_matched;
    end

endmodule
`default_nettype wire

### src/rfas_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rfas_checker
// Port-level checks for the reverse flow ack suppress table.
// ----------------------------------------------------------------------------
module rfas_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_in_valid,
    input wire logic        o_in_stall,
    input wire logic        i_operation,
    input wire logic        o_out_valid,
    input wire logic        i_out_stall,
    input wire logic        o_matched
);

    logic in_xfer;
    assign in_xfer = i_in_valid && !o_in_stall;

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_matched))
        else $error("result changed while stalled");

    // no new transfer while a result is blocked
    a_in_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |-> o_in_stall)
        else $error("input taken while output blocked");

    // record gives an immediate no-match result
    a_record_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer && (i_operation == rfas_pkg::OP_RECORD) |=> o_out_valid && !o_matched)
        else $error("record result missing or wrong");

    // check occupies the block while it scans
    a_check_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer && (i_operation == rfas_pkg::OP_CHECK) |=> o_in_stall)
        else $error("input taken during scan");

endmodule

bind reverse_flow_ack_suppress_table rfas_checker u_rfas_checker (.*);
`default_nettype wire
